// ----- rtl/core/ippm_pkg.sv -----
// Shared types, register indexes and reset values of the IR pulse pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
package ippm_pkg;

    localparam int WIDTH_BITS_DEF = 12;

    localparam int REF_W   = 12;
    localparam int GAP_W   = 13;
    localparam int DIV_W   = 8;
    localparam int BLANK_W = 10;
    localparam int OUT_W   = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_REF_FIRST   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SECOND  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_THIRD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DIV    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIV    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS = 8'd7;

    localparam logic [REF_W-1:0]   RST_REF_FIRST   = 12'd206;
    localparam logic [REF_W-1:0]   RST_REF_SECOND  = 12'd172;
    localparam logic [REF_W-1:0]   RST_REF_THIRD   = 12'd259;
    localparam logic [REF_W-1:0]   RST_TOLERANCE   = 12'd30;
    localparam logic [GAP_W-1:0]   RST_GAP_LIMIT   = 13'd5500;
    localparam logic [DIV_W-1:0]   RST_FAST_DIV    = 8'd3;
    localparam logic [DIV_W-1:0]   RST_SLOW_DIV    = 8'd10;
    localparam logic [BLANK_W-1:0] RST_BLANK_TICKS = 10'd50;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_P1   = 4'd1,
        PH_B1   = 4'd2,
        PH_G1   = 4'd3,
        PH_P2   = 4'd4,
        PH_B2   = 4'd5,
        PH_G2   = 4'd6,
        PH_P3   = 4'd7,
        PH_B3   = 4'd8
    } t_phase;

    typedef struct packed {
        logic [REF_W-1:0]   ref_first;
        logic [REF_W-1:0]   ref_second;
        logic [REF_W-1:0]   ref_third;
        logic [REF_W-1:0]   tolerance;
        logic [GAP_W-1:0]   gap_limit;
        logic [DIV_W-1:0]   fast_div;
        logic [DIV_W-1:0]   slow_div;
        logic [BLANK_W-1:0] blank_ticks;
    } t_cfg;

    typedef struct packed {
        logic             frame_match;
        logic             gap_timeout;
        logic [OUT_W-1:0] width_one;
        logic [OUT_W-1:0] width_two;
        logic [OUT_W-1:0] width_three;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/ippm_cfg.sv -----
// Configuration register file of the IR pulse pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
module ippm_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ippm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ippm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ippm_pkg::t_cfg                        o_cfg
);

    ippm_pkg::t_cfg r_cfg;
    logic           n_wr;

    assign o_cfg_ready = 1'b1;
    assign n_wr        = i_cfg_valid & o_cfg_ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_first   <= ippm_pkg::RST_REF_FIRST;
            r_cfg.ref_second  <= ippm_pkg::RST_REF_SECOND;
            r_cfg.ref_third   <= ippm_pkg::RST_REF_THIRD;
            r_cfg.tolerance   <= ippm_pkg::RST_TOLERANCE;
            r_cfg.gap_limit   <= ippm_pkg::RST_GAP_LIMIT;
            r_cfg.fast_div    <= ippm_pkg::RST_FAST_DIV;
            r_cfg.slow_div    <= ippm_pkg::RST_SLOW_DIV;
            r_cfg.blank_ticks <= ippm_pkg::RST_BLANK_TICKS;
        end else if (n_wr) begin
            // drop writes to indexes past the register list
            case (i_cfg_index)
                ippm_pkg::REG_REF_FIRST:   r_cfg.ref_first   <= i_cfg_data[ippm_pkg::REF_W-1:0];
                ippm_pkg::REG_REF_SECOND:  r_cfg.ref_second  <= i_cfg_data[ippm_pkg::REF_W-1:0];
                ippm_pkg::REG_REF_THIRD:   r_cfg.ref_third   <= i_cfg_data[ippm_pkg::REF_W-1:0];
                ippm_pkg::REG_TOLERANCE:   r_cfg.tolerance   <= i_cfg_data[ippm_pkg::REF_W-1:0];
                ippm_pkg::REG_GAP_LIMIT:   r_cfg.gap_limit   <= i_cfg_data[ippm_pkg::GAP_W-1:0];
                ippm_pkg::REG_FAST_DIV:    r_cfg.fast_div    <= i_cfg_data[ippm_pkg::DIV_W-1:0];
                ippm_pkg::REG_SLOW_DIV:    r_cfg.slow_div    <= i_cfg_data[ippm_pkg::DIV_W-1:0];
                ippm_pkg::REG_BLANK_TICKS: r_cfg.blank_ticks <= i_cfg_data[ippm_pkg::BLANK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ippm_core.sv -----
// Frame sequencer: pulse, blanking and gap timing, result formation.
`timescale 1ns / 1ps
`default_nettype none
module ippm_core #(
    parameter int WIDTH_BITS = ippm_pkg::WIDTH_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_level,
    input  ippm_pkg::t_cfg      i_cfg,
    output logic                o_emit,
    output ippm_pkg::t_result   o_result
);

    localparam int CW = (WIDTH_BITS > ippm_pkg::REF_W) ? WIDTH_BITS : ippm_pkg::REF_W;
    localparam logic [WIDTH_BITS-1:0]       WMAX = {WIDTH_BITS{1'b1}};
    localparam logic [ippm_pkg::GAP_W-1:0]  GMAX = {ippm_pkg::GAP_W{1'b1}};
    localparam logic [WIDTH_BITS-1:0]       WONE = WIDTH_BITS'(1);

    ippm_pkg::t_phase               r_phase, n_phase;
    logic                           r_last;
    logic [ippm_pkg::DIV_W-1:0]     r_ps, n_ps;
    logic [WIDTH_BITS-1:0]          r_pc, n_pc;
    logic [ippm_pkg::GAP_W-1:0]     r_gc, n_gc, gc_inc;
    logic [ippm_pkg::BLANK_W-1:0]   r_bc, n_bc;
    logic [WIDTH_BITS-1:0]          r_fw, n_fw;
    logic [WIDTH_BITS-1:0]          r_sw, n_sw;

    logic                           e_fire;
    logic                           e_timeout;
    logic                           e_keep_sw;
    logic                           pulse_p1;
    ippm_pkg::t_phase               gap_ph;
    logic [WIDTH_BITS-1:0]          w2_sel, w3_sel;

    function automatic logic [ippm_pkg::DIV_W-1:0] next_ps(
        input logic [ippm_pkg::DIV_W-1:0] cur,
        input logic [ippm_pkg::DIV_W-1:0] div
    );
        logic [ippm_pkg::DIV_W:0] d;
        logic [ippm_pkg::DIV_W:0] n;
        d = (div == '0) ? (ippm_pkg::DIV_W+1)'(1) : {1'b0, div};
        n = {1'b0, cur} + (ippm_pkg::DIV_W+1)'(1);
        return (n >= d) ? '0 : n[ippm_pkg::DIV_W-1:0];
    endfunction

    function automatic logic near_ref(
        input logic [ippm_pkg::REF_W-1:0] ref_val,
        input logic [WIDTH_BITS-1:0]      w,
        input logic [ippm_pkg::REF_W-1:0] tol
    );
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] diff;
        a    = CW'(ref_val);
        b    = CW'(w);
        diff = (a > b) ? (a - b) : (b - a);
        return diff < CW'(tol);
    endfunction

    function automatic logic [ippm_pkg::OUT_W-1:0] to_out(input logic [WIDTH_BITS-1:0] w);
        logic [CW-1:0] x;
        x = CW'(w);
        return x[ippm_pkg::OUT_W-1:0];
    endfunction

    assign pulse_p1 = (r_phase == ippm_pkg::PH_P1);
    assign gap_ph   = (r_phase == ippm_pkg::PH_B1) ? ippm_pkg::PH_G1 : ippm_pkg::PH_G2;
    assign gc_inc   = (r_gc < GMAX) ? (r_gc + ippm_pkg::GAP_W'(1)) : r_gc;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_ps      = r_ps;
        n_pc      = r_pc;
        n_gc      = r_gc;
        n_bc      = r_bc;
        n_fw      = r_fw;
        n_sw      = r_sw;
        e_fire    = 1'b0;
        e_timeout = 1'b0;
        e_keep_sw = 1'b0;
        unique case (r_phase)
            ippm_pkg::PH_IDLE: begin
                if (r_last && !i_level) begin
                    n_fw    = '0;
                    n_sw    = '0;
                    n_pc    = WONE;
                    n_ps    = next_ps('0, i_cfg.fast_div);
                    n_phase = ippm_pkg::PH_P1;
                end
            end
            ippm_pkg::PH_P1, ippm_pkg::PH_P2, ippm_pkg::PH_P3: begin
                if (r_ps == '0 && i_level) begin
                    if (r_phase == ippm_pkg::PH_P1) n_fw = r_pc;
                    if (r_phase == ippm_pkg::PH_P2) n_sw = r_pc;
                    n_bc = i_cfg.blank_ticks;
                    n_ps = '0;
                    unique case (r_phase)
                        ippm_pkg::PH_P1: n_phase = ippm_pkg::PH_B1;
                        ippm_pkg::PH_P2: n_phase = ippm_pkg::PH_B2;
                        default:         n_phase = ippm_pkg::PH_B3;
                    endcase
                end else begin
                    if (r_ps == '0 && r_pc < WMAX) n_pc = r_pc + WONE;
                    n_ps = next_ps(r_ps, pulse_p1 ? i_cfg.fast_div : i_cfg.slow_div);
                end
            end
            ippm_pkg::PH_B1, ippm_pkg::PH_B2, ippm_pkg::PH_B3: begin
                if (r_bc != '0) begin
                    n_bc = r_bc - ippm_pkg::BLANK_W'(1);
                end else if (r_phase == ippm_pkg::PH_B3) begin
                    e_fire  = 1'b1;
                    n_phase = ippm_pkg::PH_IDLE;
                end else begin
                    // this tick is the first gap sample
                    n_gc = '0;
                    n_ps = '0;
                    if (i_level) begin
                        n_gc = ippm_pkg::GAP_W'(1);
                        if (ippm_pkg::GAP_W'(1) > i_cfg.gap_limit) begin
                            e_fire    = 1'b1;
                            e_timeout = 1'b1;
                            e_keep_sw = (gap_ph == ippm_pkg::PH_G2);
                            n_phase   = ippm_pkg::PH_IDLE;
                        end else begin
                            n_ps    = next_ps('0, i_cfg.fast_div);
                            n_phase = gap_ph;
                        end
                    end else begin
                        n_pc    = WONE;
                        n_ps    = next_ps('0, i_cfg.slow_div);
                        n_phase = (gap_ph == ippm_pkg::PH_G1) ? ippm_pkg::PH_P2 : ippm_pkg::PH_P3;
                    end
                end
            end
            ippm_pkg::PH_G1, ippm_pkg::PH_G2: begin
                if (r_ps == '0) begin
                    if (i_level) begin
                        n_gc = gc_inc;
                        if (gc_inc > i_cfg.gap_limit) begin
                            e_fire    = 1'b1;
                            e_timeout = 1'b1;
                            e_keep_sw = (r_phase == ippm_pkg::PH_G2);
                            n_phase   = ippm_pkg::PH_IDLE;
                        end else begin
                            n_ps = next_ps('0, i_cfg.fast_div);
                        end
                    end else begin
                        n_pc    = WONE;
                        n_ps    = next_ps('0, i_cfg.slow_div);
                        n_phase = (r_phase == ippm_pkg::PH_G1) ? ippm_pkg::PH_P2
                                                               : ippm_pkg::PH_P3;
                    end
                end else begin
                    n_ps = next_ps(r_ps, i_cfg.fast_div);
                end
            end
            default: n_phase = ippm_pkg::PH_IDLE;
        endcase
    end

    // result formation
    always_comb begin
        w2_sel = (e_timeout && !e_keep_sw) ? '0 : r_sw;
        w3_sel = e_timeout ? '0 : r_pc;
        o_emit = i_en & e_fire;
        o_result.gap_timeout = e_timeout;
        o_result.frame_match = !e_timeout
                             && near_ref(i_cfg.ref_first,  r_fw,   i_cfg.tolerance)
                             && near_ref(i_cfg.ref_second, w2_sel, i_cfg.tolerance)
                             && near_ref(i_cfg.ref_third,  w3_sel, i_cfg.tolerance);
        o_result.width_one   = to_out(r_fw);
        o_result.width_two   = to_out(w2_sel);
        o_result.width_three = to_out(w3_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ippm_pkg::PH_IDLE;
            r_last  <= 1'b1;
            r_ps    <= '0;
            r_pc    <= '0;
            r_gc    <= '0;
            r_bc    <= '0;
            r_fw    <= '0;
            r_sw    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_last  <= i_level;
            r_ps    <= n_ps;
            r_pc    <= n_pc;
            r_gc    <= n_gc;
            r_bc    <= n_bc;
            r_fw    <= n_fw;
            r_sw    <= n_sw;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ippm_out.sv -----
// Result register with a skid stage between the sequencer and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module ippm_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ippm_pkg::t_result   i_data,
    output logic                o_space,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ippm_pkg::t_result   o_data
);

    logic              r_main_valid, r_skid_valid;
    ippm_pkg::t_result r_main, r_skid;
    logic              n_pop;

    assign n_pop   = r_main_valid & i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || n_pop) begin
            // advance the skid entry first to keep order
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || n_pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ir_pulse_pattern_matcher.sv -----
// Top level of the IR pulse pattern matcher.
//
// Sample channel: one receiver level per tick on i_line_level, transferred
// when i_valid and o_ready are both high. Every transfer steps the frame
// sequencer once, so a sample may follow in every cycle while o_ready is high.
// Result channel: one transfer per finished frame (three pulses measured, or
// a gap timeout), with o_valid and i_ready. The sample that completes the
// frame registers its result into the result register or the skid entry.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index and
// data; o_cfg_ready is always high and a write is registered on transfer. Indexes
// past the register list are ignored.
// Throughput is one sample per cycle while o_ready is high, as the sequencer
// updates on every accepted sample. The result register plus a skid entry let
// sampling continue while a result waits; o_ready drops only when both hold a
// result, i.e. when the receiver stalls across two frame ends.
// Reset (synchronous, active low) returns the sequencer to idle with the
// line taken as high, empties the output stage and loads the default
// register values.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_pattern_matcher #(
    parameter int WIDTH_BITS = ippm_pkg::WIDTH_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_line_level,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_frame_match,
    output logic                                  o_gap_timeout,
    output logic [ippm_pkg::OUT_W-1:0]            o_width_one,
    output logic [ippm_pkg::OUT_W-1:0]            o_width_two,
    output logic [ippm_pkg::OUT_W-1:0]            o_width_three,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ippm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ippm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ippm_pkg::t_cfg    cfg;
    ippm_pkg::t_result core_res, out_res;
    logic              core_emit;
    logic              out_space;
    logic              accept;

    assign o_ready = out_space;
    assign accept  = i_valid & out_space;

    ippm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ippm_core #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_level  (i_line_level),
        .i_cfg    (cfg),
        .o_emit   (core_emit),
        .o_result (core_res)
    );

    ippm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_emit),
        .i_data  (core_res),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    assign o_frame_match = out_res.frame_match;
    assign o_gap_timeout = out_res.gap_timeout;
    assign o_width_one   = out_res.width_one;
    assign o_width_two   = out_res.width_two;
    assign o_width_three = out_res.width_three;

endmodule
`default_nettype wire

// ----- tb/sv/ir_pulse_pattern_matcher_test.sv -----
// Self-checking testbench for the IR pulse pattern matcher: frame predictor, drivers and checks.
`timescale 1ns / 1ps
module ir_pulse_pattern_matcher_test;
    import ippm_pkg::*;

    // Tracks the frame sequencer sample by sample and holds the frame reports still owed.
    class frame_tracker;
        t_cfg                 cfg;
        t_phase               phase;
        logic                 last_level;
        logic [DIV_W-1:0]     prescale;
        logic [OUT_W-1:0]     pulse;
        logic [GAP_W-1:0]     gap;
        logic [BLANK_W-1:0]   blank;
        logic [OUT_W-1:0]     w_first;
        logic [OUT_W-1:0]     w_second;
        t_result              due_frames[$];
        int unsigned          samples, frames_predicted, frames_matched, frames_timed_out;
        int unsigned          reports_checked, reg_writes, errors;

        function new();
            cfg = '{ref_first: RST_REF_FIRST, ref_second: RST_REF_SECOND,
                    ref_third: RST_REF_THIRD, tolerance: RST_TOLERANCE,
                    gap_limit: RST_GAP_LIMIT, fast_div: RST_FAST_DIV,
                    slow_div: RST_SLOW_DIV, blank_ticks: RST_BLANK_TICKS};
            phase = PH_IDLE;
            last_level = 1'b1;
            prescale = '0;
            pulse = '0;
            gap = '0;
            blank = '0;
            w_first = '0;
            w_second = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_REF_FIRST:   cfg.ref_first = data[REF_W-1:0];
                REG_REF_SECOND:  cfg.ref_second = data[REF_W-1:0];
                REG_REF_THIRD:   cfg.ref_third = data[REF_W-1:0];
                REG_TOLERANCE:   cfg.tolerance = data[REF_W-1:0];
                REG_GAP_LIMIT:   cfg.gap_limit = data[GAP_W-1:0];
                REG_FAST_DIV:    cfg.fast_div = data[DIV_W-1:0];
                REG_SLOW_DIV:    cfg.slow_div = data[DIV_W-1:0];
                REG_BLANK_TICKS: cfg.blank_ticks = data[BLANK_W-1:0];
                default: ;
            endcase
        endfunction

        // A divider of zero counts as one.
        function logic [DIV_W-1:0] tick_after(logic [DIV_W-1:0] cur, logic [DIV_W-1:0] div);
            logic [DIV_W:0]   n;
            logic [DIV_W:0]   d;
            d = (div == '0) ? (DIV_W+1)'(1) : {1'b0, div};
            n = {1'b0, cur} + (DIV_W+1)'(1);
            return (n >= d) ? '0 : n[DIV_W-1:0];
        endfunction

        function bit near_ref(logic [REF_W-1:0] r, logic [OUT_W-1:0] w);
            logic [REF_W-1:0] diff;
            diff = (r > w) ? r - w : w - r;
            return diff < cfg.tolerance;
        endfunction

        function void add_frame(bit timeout, logic [OUT_W-1:0] w1, logic [OUT_W-1:0] w2,
                                logic [OUT_W-1:0] w3);
            t_result r;
            r.gap_timeout = timeout;
            r.frame_match = !timeout && near_ref(cfg.ref_first, w1)
                            && near_ref(cfg.ref_second, w2) && near_ref(cfg.ref_third, w3);
            r.width_one = w1;
            r.width_two = w2;
            r.width_three = w3;
            frames_predicted++;
            if (r.frame_match) frames_matched++;
            if (timeout) frames_timed_out++;
            due_frames.push_back(r);
        endfunction

        // Gap sample tick: high extends the gap, low opens the next pulse.
        function void gap_sample(logic lvl);
            if (lvl) begin
                if (gap != {GAP_W{1'b1}}) gap++;
                if (gap > cfg.gap_limit) begin
                    add_frame(1'b1, w_first, (phase == PH_G2) ? w_second : '0, '0);
                    phase = PH_IDLE;
                end else begin
                    prescale = tick_after('0, cfg.fast_div);
                end
            end else begin
                pulse = 1;
                prescale = tick_after('0, cfg.slow_div);
                phase = t_phase'(phase + 1);
            end
        endfunction

        function void note_sample(logic lvl);
            logic [DIV_W-1:0] div;
            samples++;
            case (phase)
                PH_IDLE: if (last_level && !lvl) begin
                    w_first = '0;
                    w_second = '0;
                    pulse = 1;
                    prescale = tick_after('0, cfg.fast_div);
                    phase = PH_P1;
                end
                PH_P1, PH_P2, PH_P3: begin
                    div = (phase == PH_P1) ? cfg.fast_div : cfg.slow_div;
                    if (prescale == 0 && lvl) begin
                        if (phase == PH_P1) w_first = pulse;
                        else if (phase == PH_P2) w_second = pulse;
                        blank = cfg.blank_ticks;
                        prescale = '0;
                        phase = t_phase'(phase + 1);
                    end else begin
                        if (prescale == 0 && pulse != {OUT_W{1'b1}}) pulse++;
                        prescale = tick_after(prescale, div);
                    end
                end
                PH_B1, PH_B2, PH_B3: begin
                    if (blank != 0) begin
                        blank--;
                    end else if (phase == PH_B3) begin
                        add_frame(1'b0, w_first, w_second, pulse);
                        phase = PH_IDLE;
                    end else begin
                        // first tick after blanking is already a gap sample
                        phase = t_phase'(phase + 1);
                        gap = '0;
                        prescale = '0;
                        gap_sample(lvl);
                    end
                end
                PH_G1, PH_G2: begin
                    if (prescale == 0) gap_sample(lvl);
                    else prescale = tick_after(prescale, cfg.fast_div);
                end
                default: phase = PH_IDLE;
            endcase
            last_level = lvl;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_frames.size() == 0) begin
                $error("frame report with none pending: match %0d timeout %0d widths %0d %0d %0d",
                       got.frame_match, got.gap_timeout, got.width_one, got.width_two,
                       got.width_three);
                errors++;
                return;
            end
            want = due_frames.pop_front();
            reports_checked++;
            compare_field("frame_match", want.frame_match, got.frame_match);
            compare_field("gap_timeout", want.gap_timeout, got.gap_timeout);
            compare_field("width_one", want.width_one, got.width_one);
            compare_field("width_two", want.width_two, got.width_two);
            compare_field("width_three", want.width_three, got.width_three);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_line_level;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_frame_match;
    logic                   o_gap_timeout;
    logic [OUT_W-1:0]       o_width_one;
    logic [OUT_W-1:0]       o_width_two;
    logic [OUT_W-1:0]       o_width_three;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    frame_tracker sb;
    bit           idle_on;
    bit           hold_now;
    int unsigned  full_stalls;

    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT = 5000;

    ir_pulse_pattern_matcher u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_sample(i_line_level);
            if (i_valid && !o_ready) full_stalls++;
            if (o_valid && i_ready)
                sb.check_result({o_frame_match, o_gap_timeout, o_width_one, o_width_two,
                                 o_width_three});
        end
    end

    // Result side: random back-pressure, plus one long hold when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_now) begin
                hold_now = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= !idle_on || ($urandom_range(0, 99) >= 21);
        end
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(logic lvl);
        while (idle_on && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_line_level <= lvl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_run(logic lvl, int unsigned n);
        repeat (n) send_sample(lvl);
    endtask

    task automatic send_bits(logic [31:0] pattern, int n);
        for (int k = n - 1; k >= 0; k--) send_sample(pattern[k]);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Write every register; optionally add junk above each width and write two unused indexes.
    task automatic load_registers(t_cfg c, bit scramble);
        logic [CFG_DATA_W-1:0] data;
        int                    w;
        for (int i = 0; i <= REG_BLANK_TICKS; i++) begin
            case (CFG_IDX_W'(i))
                REG_REF_FIRST:  begin data = CFG_DATA_W'(c.ref_first);  w = REF_W; end
                REG_REF_SECOND: begin data = CFG_DATA_W'(c.ref_second); w = REF_W; end
                REG_REF_THIRD:  begin data = CFG_DATA_W'(c.ref_third);  w = REF_W; end
                REG_TOLERANCE:  begin data = CFG_DATA_W'(c.tolerance);  w = REF_W; end
                REG_GAP_LIMIT:  begin data = CFG_DATA_W'(c.gap_limit);  w = GAP_W; end
                REG_FAST_DIV:   begin data = CFG_DATA_W'(c.fast_div);   w = DIV_W; end
                REG_SLOW_DIV:   begin data = CFG_DATA_W'(c.slow_div);   w = DIV_W; end
                default:        begin data = CFG_DATA_W'(c.blank_ticks); w = BLANK_W; end
            endcase
            if (scramble)
                data |= CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << w) - CFG_DATA_W'(1));
            cfg_write(CFG_IDX_W'(i), data);
        end
        if (scramble) begin
            cfg_write(CFG_IDX_W'(REG_BLANK_TICKS + 1), CFG_DATA_W'($urandom));
            cfg_write('1, CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        while (sb.due_frames.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        if (sb.due_frames.size() != 0) begin
            $error("%0d frame reports never arrived", sb.due_frames.size());
            sb.errors++;
            sb.due_frames.delete();
        end
    endtask

    // Drive the sequencer back to idle, then let the output stage empty.
    task automatic settle_block();
        while (sb.phase != PH_IDLE)
            send_sample((sb.phase == PH_G1 || sb.phase == PH_G2) ? 1'b0 : 1'b1);
        i_valid <= 1'b0;
        wait_drain();
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_cfg pick_config();
        t_cfg c;
        c.ref_first = REF_W'($urandom_range(0, 6));
        c.ref_second = REF_W'($urandom_range(0, 6));
        c.ref_third = REF_W'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0:       c.tolerance = '0;
            1:       c.tolerance = '1;
            default: c.tolerance = REF_W'($urandom_range(1, 5));
        endcase
        c.gap_limit = ($urandom_range(0, 5) == 0) ? '0 : GAP_W'($urandom_range(2, 6));
        c.fast_div = DIV_W'($urandom_range(0, 4));
        c.slow_div = DIV_W'($urandom_range(0, 4));
        c.blank_ticks = BLANK_W'($urandom_range(0, 4));
        return c;
    endfunction

    // Low run length that mostly lands near the reference count.
    function automatic int unsigned pulse_ticks(int unsigned target, int unsigned div);
        int unsigned j;
        int          c;
        j = (sb.cfg.tolerance > 3) ? 3 : sb.cfg.tolerance;
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, (target + 3) * div);
        c = int'(target) + int'($urandom_range(0, 2 * j + 2)) - int'(j + 1);
        if (c < 1) c = 1;
        return int'(c - 1) * div + 1 + $urandom_range(0, div - 1);
    endfunction

    function automatic int unsigned gap_ticks(int unsigned blank, int unsigned div,
                                              int unsigned limit);
        if ($urandom_range(0, 7) == 0) return blank + (limit + 2) * div + $urandom_range(0, div);
        return blank + 1 + $urandom_range(0, limit * div);
    endfunction

    task automatic send_frame();
        int unsigned f, s, b, gl, shape;
        f = (sb.cfg.fast_div == 0) ? 1 : sb.cfg.fast_div;
        s = (sb.cfg.slow_div == 0) ? 1 : sb.cfg.slow_div;
        b = sb.cfg.blank_ticks;
        gl = sb.cfg.gap_limit;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(4, 40)) send_sample($urandom_range(0, 1));
            return;
        end
        send_run(1'b1, $urandom_range(1, 3));
        send_run(1'b0, pulse_ticks(sb.cfg.ref_first, f));
        send_run(1'b1, gap_ticks(b, f, gl));
        // cut the frame short and let the next one run into it
        if (shape == 1) return;
        send_run(1'b0, pulse_ticks(sb.cfg.ref_second, s));
        send_run(1'b1, gap_ticks(b, f, gl));
        send_run(1'b0, pulse_ticks(sb.cfg.ref_third, s));
        send_run(1'b1, b + 2 + $urandom_range(0, 3));
    endtask

    initial begin
        t_cfg        c;
        int unsigned start_samples, start_frames;

        sb = new();
        idle_on = 1'b1;
        hold_now = 1'b0;
        full_stalls = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_line_level = 1'b1;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Shortest frames: one count per pulse, no blanking, gap limit of one.
        c = '{ref_first: 1, ref_second: 1, ref_third: 1, tolerance: 1, gap_limit: 1,
              fast_div: 1, slow_div: 1, blank_ticks: 0};
        load_registers(c, 1'b0);
        send_bits(32'b0101010, 7);   // full match, ends idle with line low
        send_bits(32'b0, 1);         // low while idle after low: no frame
        send_bits(32'b10111, 5);     // timeout in first gap
        send_bits(32'b010111, 6);    // timeout in second gap
        send_bits(32'b00101011, 8);  // first width off by one: no match
        settle_block();

        for (int p = 0; p < 5; p++) begin
            idle_on = (p != 0);
            load_registers(pick_config(), 1'b1);
            if (p == 2) hold_now = 1'b1;
            start_samples = sb.samples;
            start_frames = sb.frames_predicted;
            while (sb.samples - start_samples < 100
                   || sb.frames_predicted - start_frames < ((p == 2) ? 3 : 2))
                send_frame();
            settle_block();
        end

        wait_drain();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d samples and %0d frame reports (%0d matched, %0d timed out).",
                 sb.samples, sb.reports_checked, sb.frames_matched, sb.frames_timed_out);
        $display("Made %0d register writes; a full output stage held off input for %0d cycles.",
                 sb.reg_writes, full_stalls);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
